/* rtl/iate_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iate_pkg
// Shared widths, opcodes and status codes of the indexed array table engine.
// ----------------------------------------------------------------------------
package iate_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OPC_W    = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_READ      = 3'd0,
    OP_INSERT    = 3'd1,
    OP_REMOVE_AT = 3'd2,
    OP_REMOVE_V  = 3'd3,
    OP_UPDATE    = 3'd4,
    OP_FIND      = 3'd5,
    OP_CLEAR     = 3'd6
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

/* rtl/iate_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iate_in_if / iate_out_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface iate_in_if;
  import iate_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic [COUNT_W-1:0]       position;
  logic signed [DATA_W-1:0] operand_value;

  modport source (output valid, output opcode, output position, output operand_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input operand_value,
                  output ready);
endinterface

interface iate_out_if;
  import iate_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     hit;
  logic [ADDR_W-1:0]        hit_index;
  logic [COUNT_W-1:0]       element_count;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output read_value, output hit, output hit_index,
                  output element_count, output status, input ready);
  modport sink   (input valid, input read_value, input hit, input hit_index,
                  input element_count, input status, output ready);
endinterface

/* rtl/indexed_array_table_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_table_engine
// Ordered array of signed words in a 1R1W memory with read, insert, remove,
// update, find and clear; shifts and searches walk the memory one entry a cycle.
// ----------------------------------------------------------------------------
// Update, clear and rejected requests need no walk; a read waits for the
// registered memory read; insert, remove and find walk the memory.
// One item at a time; the single memory read port sets the walk rate.
// Reset clears the count and the handshake state; memory contents are kept.
// ----------------------------------------------------------------------------
module indexed_array_table_engine (
  input  logic      clk,
  input  logic      rst_n,
  iate_in_if.sink   in_chan,
  iate_out_if.source out_chan
);
  import iate_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SEARCH,
    S_FINISH
  } state_t;

  // Element memory
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;

  // Control and result registers
  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  opcode_t            op_r, op_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic [ADDR_W-1:0]  scan_r, scan_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  tag_r, tag_nxt;
  logic [DATA_W-1:0]  res_rd_r, res_rd_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic [ADDR_W-1:0]  res_idx_r, res_idx_nxt;
  status_t            res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_rd_r, out_rd_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [ADDR_W-1:0]  out_idx_r, out_idx_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  status_t            out_st_r, out_st_nxt;

  logic               accept;
  logic               out_free;
  logic               rd_en;
  opcode_t            in_op;
  logic [COUNT_W-1:0] in_pos;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign rd_en         = (rem_r != '0);
  assign in_op         = opcode_t'(in_chan.opcode);
  assign in_pos        = in_chan.position;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.read_value    = out_rd_r;
  assign out_chan.hit           = out_hit_r;
  assign out_chan.hit_index     = out_idx_r;
  assign out_chan.element_count = out_cnt_r;
  assign out_chan.status        = out_st_r;

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Sequencer: decode, walk the memory, build the result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    scan_nxt      = scan_r;
    rem_nxt       = rem_r;
    pend_nxt      = 1'b0;
    tag_nxt       = tag_r;
    res_rd_nxt    = res_rd_r;
    res_hit_nxt   = res_hit_r;
    res_idx_nxt   = res_idx_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_rd_nxt    = out_rd_r;
    out_hit_nxt   = out_hit_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    we            = 1'b0;
    waddr         = scan_r;
    wdata         = rdata_r;
    raddr         = scan_r;

    case (state_r)
      S_IDLE: begin
        raddr = in_pos[ADDR_W-1:0];
        if (accept) begin
          op_nxt      = in_op;
          pos_nxt     = in_pos[ADDR_W-1:0];
          val_nxt     = in_chan.operand_value;
          res_rd_nxt  = '0;
          res_hit_nxt = 1'b0;
          res_idx_nxt = '0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_FINISH;
          case (in_op)
            OP_READ: begin
              if (in_pos >= count_r) res_st_nxt = ST_RANGE;
              else                   state_nxt  = S_RD_WAIT;
            end
            OP_INSERT: begin
              if (count_r == COUNT_W'(CAPACITY)) begin
                res_st_nxt = ST_FULL;
              end else if (in_pos > count_r) begin
                res_st_nxt = ST_RANGE;
              end else begin
                scan_nxt  = ADDR_W'(count_r - 1'b1);
                rem_nxt   = count_r - in_pos;
                state_nxt = S_SHIFT_UP;
              end
            end
            OP_REMOVE_AT: begin
              if (count_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else if (in_pos >= count_r) begin
                res_st_nxt = ST_RANGE;
              end else begin
                scan_nxt  = ADDR_W'(in_pos + 1'b1);
                rem_nxt   = count_r - 1'b1 - in_pos;
                state_nxt = S_SHIFT_DN;
              end
            end
            OP_REMOVE_V: begin
              if (count_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                scan_nxt  = '0;
                rem_nxt   = count_r;
                state_nxt = S_SEARCH;
              end
            end
            OP_UPDATE: begin
              if (in_pos >= count_r) begin
                res_st_nxt = ST_RANGE;
              end else begin
                we    = 1'b1;
                waddr = in_pos[ADDR_W-1:0];
                wdata = in_chan.operand_value;
              end
            end
            OP_FIND: begin
              scan_nxt  = '0;
              rem_nxt   = count_r;
              state_nxt = S_SEARCH;
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      // Capture the element read at the accepted position
      S_RD_WAIT: begin
        res_rd_nxt = rdata_r;
        state_nxt  = S_FINISH;
      end

      // Move each entry up by one, from the tail down to the position
      S_SHIFT_UP: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = tag_r;
          wdata = rdata_r;
        end
        if (rd_en) begin
          raddr    = scan_r;
          tag_nxt  = scan_r + 1'b1;
          pend_nxt = 1'b1;
          scan_nxt = scan_r - 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else if (!pend_r) begin
          we        = 1'b1;
          waddr     = pos_r;
          wdata     = val_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_FINISH;
        end
      end

      // Move each entry down by one, from behind the removed one to the tail
      S_SHIFT_DN: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = tag_r;
          wdata = rdata_r;
        end
        if (rd_en) begin
          raddr    = scan_r;
          tag_nxt  = scan_r - 1'b1;
          pend_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else if (!pend_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FINISH;
        end
      end

      // Compare entries from index zero up; stop at the first match
      S_SEARCH: begin
        if (pend_r && (rdata_r == val_r)) begin
          res_hit_nxt = 1'b1;
          res_idx_nxt = tag_r;
          if (op_r == OP_REMOVE_V) begin
            scan_nxt  = tag_r + 1'b1;
            rem_nxt   = count_r - 1'b1 - {1'b0, tag_r};
            state_nxt = S_SHIFT_DN;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (rd_en) begin
          raddr    = scan_r;
          tag_nxt  = scan_r;
          pend_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_FINISH;
        end
      end

      // Hand the result to the output register once it is free
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_hit_nxt   = res_hit_r;
          out_idx_nxt   = res_idx_r;
          out_cnt_nxt   = count_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    scan_r    <= scan_nxt;
    tag_r     <= tag_nxt;
    res_rd_r  <= res_rd_nxt;
    res_hit_r <= res_hit_nxt;
    res_idx_r <= res_idx_nxt;
    res_st_r  <= res_st_nxt;
    out_rd_r  <= out_rd_nxt;
    out_hit_r <= out_hit_nxt;
    out_idx_r <= out_idx_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

endmodule

/* dv/indexed_array_table_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_table_engine_tb
// Self-checking bench for the array engine. Requests are driven on the
// valid/ready input channel, and each one is mirrored into a local copy of
// the array that predicts its reply. Replies are checked in order, field by
// field. The run covers the empty and full corners, a full-depth fill,
// a long output stall and a long random mix with idle cycles on both sides.
// ----------------------------------------------------------------------------
module indexed_array_table_engine_tb;
  import iate_pkg::*;

  localparam int                 HALF_PERIOD  = 2;
  localparam int                 RESET_CYCLES = 9;
  localparam int                 IDLE_PCT     = 26;
  localparam int                 STALL_CYCLES = 400;
  localparam int                 RANDOM_ITEMS = 390;
  localparam int                 SETTLE       = 2 * CAPACITY + 32;
  localparam logic [OPC_W-1:0]   OP_SPARE     = 3'd7;
  localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX      = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     hit;
    logic [ADDR_W-1:0]        hit_index;
    logic [COUNT_W-1:0]       element_count;
    status_t                  status;
  } table_reply_t;

  logic clk;
  logic rst_n;

  iate_in_if  req_ch ();
  iate_out_if rsp_ch ();

  indexed_array_table_engine uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (rsp_ch)
  );

  // Mirror of the array contents and fill level
  logic signed [DATA_W-1:0] mirror_store [CAPACITY];
  int                       mirror_count;

  table_reply_t table_replies_q [$];
  int           error_count;
  int           items_sent;
  int           replies_checked;
  int           op_hist [8];
  int           peak_count;
  bit           idle_on;
  bit           stall_req;
  int           stall_left;

  // Free-running clock
  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("%0t timeout with %0d replies pending", $time, table_replies_q.size());
    $display("FAIL indexed_array_table_engine");
    $finish;
  end

  // Compute the reply to one request and advance the mirror
  function automatic table_reply_t predict_table_op(logic [OPC_W-1:0] op,
                                                    logic [COUNT_W-1:0] pos,
                                                    logic signed [DATA_W-1:0] val);
    table_reply_t r;
    int           p;
    int           f;
    r    = '0;
    r.status = ST_OK;
    p    = int'(pos);
    f    = -1;
    case (op)
      OP_READ: begin
        if (p >= mirror_count) r.status = ST_RANGE;
        else r.read_value = mirror_store[p];
      end
      OP_INSERT: begin
        if (mirror_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p > mirror_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = mirror_count; i > p; i--) mirror_store[i] = mirror_store[i-1];
          mirror_store[p] = val;
          mirror_count++;
        end
      end
      OP_REMOVE_AT: begin
        if (mirror_count == 0) r.status = ST_EMPTY;
        else if (p >= mirror_count) r.status = ST_RANGE;
        else f = p;
      end
      OP_REMOVE_V, OP_FIND: begin
        if (op == OP_REMOVE_V && mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < mirror_count; i++) begin
            if (mirror_store[i] == val) begin
              r.hit       = 1'b1;
              r.hit_index = ADDR_W'(i);
              break;
            end
          end
          if (r.hit && op == OP_REMOVE_V) f = int'(r.hit_index);
        end
      end
      OP_UPDATE: begin
        if (p >= mirror_count) r.status = ST_RANGE;
        else mirror_store[p] = val;
      end
      OP_CLEAR: mirror_count = 0;
      default: ;
    endcase
    // Close the gap behind a removed entry
    if (f >= 0) begin
      for (int i = f; i + 1 < mirror_count; i++) mirror_store[i] = mirror_store[i+1];
      mirror_count--;
    end
    if (mirror_count > peak_count) peak_count = mirror_count;
    r.element_count = COUNT_W'(mirror_count);
    return r;
  endfunction

  // Offer one request, hold it until accepted, then predict its reply
  task automatic send_item(logic [OPC_W-1:0] op, int pos, logic signed [DATA_W-1:0] val);
    @(negedge clk);
    if (idle_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.position      <= COUNT_W'(pos);
    req_ch.operand_value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    table_replies_q.push_back(predict_table_op(op, COUNT_W'(pos), val));
    items_sent++;
    op_hist[op]++;
  endtask

  // Drop valid once the current burst is done
  task automatic release_input();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_replies_drained();
    while (table_replies_q.size() != 0) @(posedge clk);
  endtask

  // Drive ready: long requested stall first, random idling otherwise
  always @(negedge clk) begin
    if (stall_req) begin
      stall_req  = 1'b0;
      stall_left = STALL_CYCLES;
    end
    if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Check each reply against the oldest prediction
  always @(posedge clk) begin
    table_reply_t exp_r;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (table_replies_q.size() == 0) begin
        $display("%0t unexpected reply: read_value %0d count %0d status %0d", $time,
                 rsp_ch.read_value, rsp_ch.element_count, rsp_ch.status);
        error_count++;
      end else begin
        exp_r = table_replies_q.pop_front();
        replies_checked++;
        if (rsp_ch.read_value !== exp_r.read_value) begin
          $display("%0t read_value mismatch: expected %0d actual %0d", $time,
                   exp_r.read_value, rsp_ch.read_value);
          error_count++;
        end
        if (rsp_ch.hit !== exp_r.hit) begin
          $display("%0t hit mismatch: expected %0d actual %0d", $time,
                   exp_r.hit, rsp_ch.hit);
          error_count++;
        end
        if (rsp_ch.hit_index !== exp_r.hit_index) begin
          $display("%0t hit_index mismatch: expected %0d actual %0d", $time,
                   exp_r.hit_index, rsp_ch.hit_index);
          error_count++;
        end
        if (rsp_ch.element_count !== exp_r.element_count) begin
          $display("%0t element_count mismatch: expected %0d actual %0d", $time,
                   exp_r.element_count, rsp_ch.element_count);
          error_count++;
        end
        if (rsp_ch.status !== exp_r.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time,
                   exp_r.status, rsp_ch.status);
          error_count++;
        end
      end
    end
  end

  // Empty-array errors, edge values, every opcode, duplicates and clear
  task automatic test_directed_corners();
    send_item(OP_READ,      0, 32'sd5);
    send_item(OP_UPDATE,    0, 32'sd5);
    send_item(OP_REMOVE_AT, 0, 32'sd0);
    send_item(OP_REMOVE_V,  0, 32'sd0);
    send_item(OP_FIND,      0, 32'sd0);
    send_item(OP_INSERT,    1, 32'sd7);
    send_item(OP_INSERT,    0, VAL_MIN);
    send_item(OP_INSERT,    1, VAL_MAX);
    send_item(OP_INSERT,    0, -32'sd1);
    send_item(OP_INSERT,    2, 32'sd0);
    send_item(OP_INSERT,    4, VAL_MAX);
    send_item(OP_READ,      3, 32'sd0);
    send_item(OP_READ,      5, 32'sd0);
    send_item(OP_UPDATE,    1, 32'sh5a5a_a5a5);
    send_item(OP_FIND,      0, VAL_MAX);
    send_item(OP_FIND,      0, 32'sd12345);
    send_item(OP_REMOVE_V,  0, VAL_MAX);
    send_item(OP_REMOVE_V,  0, 32'sd12345);
    send_item(OP_REMOVE_AT, 4, 32'sd0);
    send_item(OP_REMOVE_AT, 0, 32'sd0);
    send_item(OP_READ,    256, 32'sd0);
    send_item(OP_SPARE,    63, VAL_MIN);
    send_item(OP_CLEAR,     0, 32'sd0);
    send_item(OP_READ,      0, 32'sd0);
    release_input();
    wait_replies_drained();
  endtask

  // Fill to capacity without idling, then probe the full and deep-index cases
  task automatic test_full_array();
    idle_on = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      send_item(OP_INSERT, (i % 16 == 0) ? $urandom_range(0, mirror_count) : mirror_count,
                $urandom());
    end
    send_item(OP_INSERT,    0, 32'sd1);
    send_item(OP_INSERT,  256, 32'sd1);
    send_item(OP_READ,    255, 32'sd0);
    send_item(OP_READ,    256, 32'sd0);
    send_item(OP_FIND,      0, mirror_store[CAPACITY-1]);
    send_item(OP_UPDATE,  255, VAL_MIN);
    send_item(OP_FIND,      0, VAL_MIN);
    send_item(OP_REMOVE_AT, 256, 32'sd0);
    send_item(OP_REMOVE_V,  0, mirror_store[200]);
    send_item(OP_REMOVE_AT, 0, 32'sd0);
    send_item(OP_INSERT,    0, VAL_MAX);
    send_item(OP_REMOVE_AT, mirror_count - 1, 32'sd0);
    send_item(OP_CLEAR,     0, 32'sd0);
    release_input();
    wait_replies_drained();
    idle_on = 1'b1;
  endtask

  // Hold replies off while requests keep coming, then pause until drained
  task automatic test_output_stall();
    stall_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_item((i < 10) ? OP_INSERT : OP_FIND, 0, 32'(i));
    end
    release_input();
    wait_replies_drained();
    send_item(OP_READ, 3, 32'sd0);
    send_item(OP_CLEAR, 0, 32'sd0);
    release_input();
    wait_replies_drained();
  endtask

  // Pick an operand: often a stored value so searches hit, else an edge or random value
  function automatic logic signed [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45 && mirror_count > 0) return mirror_store[$urandom_range(0, mirror_count - 1)];
    if (roll < 65) begin
      case ($urandom_range(0, 4))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -32'sd1;
        3: return 32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom();
  endfunction

  // Random mix of opcodes with mostly legal positions
  task automatic test_random_ops();
    int               roll;
    int               ins_w;
    int               pos;
    logic [OPC_W-1:0] op;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Keep the array moderate so walks stay short
      ins_w = (mirror_count < 8) ? 45 : (mirror_count > 60) ? 10 : 25;
      roll  = $urandom_range(0, 99 + ins_w);
      if (roll < ins_w)         op = OP_INSERT;
      else if (roll < ins_w + 15) op = OP_READ;
      else if (roll < ins_w + 30) op = OP_FIND;
      else if (roll < ins_w + 45) op = OP_REMOVE_AT;
      else if (roll < ins_w + 60) op = OP_REMOVE_V;
      else if (roll < ins_w + 75) op = OP_UPDATE;
      else if (roll < ins_w + 78) op = OP_CLEAR;
      else if (roll < ins_w + 80) op = OP_SPARE;
      else                       op = opcode_t'($urandom_range(0, 5));
      if ($urandom_range(0, 99) < 80) begin
        if (op == OP_INSERT) pos = $urandom_range(0, mirror_count);
        else pos = (mirror_count > 0) ? $urandom_range(0, mirror_count - 1) : 0;
      end else begin
        pos = $urandom_range(0, 256);
      end
      send_item(op, pos, pick_value());
    end
    release_input();
    wait_replies_drained();
  endtask

  initial begin
    error_count     = 0;
    items_sent      = 0;
    replies_checked = 0;
    peak_count      = 0;
    mirror_count    = 0;
    idle_on         = 1'b1;
    stall_req       = 1'b0;
    stall_left      = 0;
    foreach (op_hist[i]) op_hist[i] = 0;
    foreach (mirror_store[i]) mirror_store[i] = '0;
    rst_n                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = '0;
    req_ch.position      = '0;
    req_ch.operand_value = '0;
    rsp_ch.ready         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_full_array();
    test_output_stall();
    test_random_ops();

    // Let any stray reply surface before the verdict
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d requests and %0d replies, peak fill %0d of %0d entries.",
             items_sent, replies_checked, peak_count, CAPACITY);
    $display("Mix: rd %0d ins %0d rm-at %0d rm-val %0d upd %0d find %0d clr %0d spare %0d",
             op_hist[0], op_hist[1], op_hist[2], op_hist[3], op_hist[4], op_hist[5],
             op_hist[6], op_hist[7]);
    if (error_count == 0) begin
      $display("PASS indexed_array_table_engine");
    end else begin
      $display("FAIL indexed_array_table_engine");
    end
    $finish;
  end

endmodule
